### rtl/scba_pkg.sv
package scba_pkg;

  // region geometry
  localparam int NumLayers = 8;
  localparam int MapBits   = 64;

  // result codes
  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_FREED    = 3'd1,
    ST_NO_CLASS = 3'd2,
    ST_FULL     = 3'd3,
    ST_BAD      = 3'd4
  } status_t;

  // request operation codes
  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  // decoded request handed to the bitmap store
  typedef struct packed {
    logic       alloc;
    logic       ok;
    status_t    fail;
    logic [2:0] layer;
    logic [3:0] lg;
    logic [5:0] slot;
  } op_t;

  // slots present in a layer: 1, 2, 4 .. 64, and 64 for the 4-byte layer
  function automatic logic [MapBits-1:0] layer_full_mask(logic [2:0] layer);
    logic [MapBits-1:0] mask;
    if (layer == 3'(NumLayers - 1)) begin
      mask = '1;
    end else begin
      mask = (MapBits'(1) << (7'd1 << layer)) - MapBits'(1);
    end
    return mask;
  endfunction

  // log2 of the slot size: 9 for layer 0 down to 2 for layer 7
  function automatic logic [3:0] layer_log2(logic [2:0] layer);
    return 4'd9 - {1'b0, layer};
  endfunction

endpackage

### rtl/scba_decode.sv
module scba_decode (
  input  logic               func,
  input  logic [15:0]        request_size,
  input  logic [11:0]        free_offset,
  output scba_pkg::op_t      op
);
  import scba_pkg::*;

  logic [8:0]  size_m1;
  logic [3:0]  msb;
  logic [3:0]  alloc_lg;
  logic [12:0] five_p;
  logic [12:0] six_size;
  logic        in_range;
  logic        tiny;
  logic [2:0]  free_layer;
  logic [3:0]  free_lg;
  logic [8:0]  layer_pos;
  logic [8:0]  free_slot;

  // size class: round up to a power of two, reject when too much is wasted
  always_comb begin
    size_m1 = request_size[8:0] - 9'd1;
    msb = 4'd0;
    for (int b = 0; b < 9; b++) begin
      if (size_m1[b]) msb = 4'(b);
    end
    alloc_lg = msb + 4'd1;
    five_p   = 13'd5 << alloc_lg;
    six_size = 13'({request_size[9:0], 2'b00}) + 13'({request_size[9:0], 1'b0});
    in_range = (request_size != 16'd0) && (request_size <= 16'd512);
    tiny     = (request_size <= 16'd4);
  end

  // free: layer from the top bits, slot from the rest
  always_comb begin
    free_layer = free_offset[11:9];
    free_lg    = layer_log2(free_layer);
    layer_pos  = free_offset[8:0];
    free_slot  = layer_pos >> free_lg;
  end

  always_comb begin
    op = '0;
    if (func == FUNC_ALLOC) begin
      op.alloc = 1'b1;
      op.fail  = ST_NO_CLASS;
      if (in_range && tiny) begin
        op.ok    = 1'b1;
        op.layer = 3'(NumLayers - 1);
        op.lg    = 4'd2;
      end else if (in_range && (five_p <= six_size)) begin
        op.ok    = 1'b1;
        op.layer = 3'(4'd9 - alloc_lg);
        op.lg    = alloc_lg;
      end
    end else begin
      op.alloc = 1'b0;
      op.fail  = ST_BAD;
      op.layer = free_layer;
      op.lg    = free_lg;
      op.slot  = free_slot[5:0];
      // only the 4-byte layer has bytes past its last slot
      op.ok    = !((free_layer == 3'(NumLayers - 1)) && layer_pos[8]);
    end
  end

endmodule

### rtl/scba_bitmaps.sv
module scba_bitmaps (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  scba_pkg::op_t      op,
  output scba_pkg::status_t  status,
  output logic [11:0]        slot_offset,
  output logic [9:0]         slot_bytes
);
  import scba_pkg::*;

  logic [MapBits-1:0] maps [NumLayers];
  logic [MapBits-1:0] cur;
  logic [MapBits-1:0] eff;
  logic [MapBits-1:0] onehot;
  logic [MapBits-1:0] map_new;
  logic [5:0]         first_free;
  logic [5:0]         slot;
  logic               full;
  logic               upd;

  // usage of the addressed layer, absent slots read as taken
  always_comb begin
    cur  = maps[op.layer];
    eff  = cur | ~layer_full_mask(op.layer);
    full = &eff;
    first_free = 6'd0;
    for (int i = MapBits - 1; i >= 0; i--) begin
      if (!eff[i]) first_free = 6'(i);
    end
  end

  // result and bitmap update
  always_comb begin
    slot    = op.alloc ? first_free : op.slot;
    onehot  = MapBits'(1) << slot;
    map_new = op.alloc ? (cur | onehot) : (cur & ~onehot);
    upd     = op.ok && !(op.alloc && full);
    status      = op.fail;
    slot_offset = 12'd0;
    slot_bytes  = 10'd0;
    if (op.ok && op.alloc && full) begin
      status = ST_FULL;
    end else if (op.ok) begin
      status      = op.alloc ? ST_GRANTED : ST_FREED;
      slot_offset = {op.layer, 9'd0} | (12'(slot) << op.lg);
      slot_bytes  = 10'd1 << op.lg;
    end
  end

  // bitmap registers, trimmed to the slots each layer owns
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NumLayers; l++) maps[l] <= '0;
    end else begin
      for (int l = 0; l < NumLayers; l++) begin
        if (en && upd && (op.layer == 3'(l))) begin
          maps[l] <= map_new & layer_full_mask(3'(l));
        end
      end
    end
  end

endmodule

### rtl/size_class_bitmap_slab_allocator_core.sv
// channel | direction | handshake            | payload
// request | in        | in_valid / in_ready  | func, request_size, free_offset
// result  | out       | out_valid / out_ready| status, slot_offset, slot_bytes
//
// One request per cycle sustained while results are taken; a result is
// presented after its request passes the request register, then the
// result register. The combinational read-modify-write of the usage bitmap
// between the two registers sets the rate; the next request sees it updated.
// Synchronous reset clears all usage bitmaps at once; no clearing pass.
// A stalled result holds the request register, which then holds in_ready low.
module size_class_bitmap_slab_allocator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [15:0]        request_size,
  input  logic [11:0]        free_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output scba_pkg::status_t  status,
  output logic [11:0]        slot_offset,
  output logic [9:0]         slot_bytes
);
  import scba_pkg::*;

  logic        req_valid;
  logic        req_func;
  logic [15:0] req_size;
  logic [11:0] req_offset;
  logic        advance;
  op_t         op;
  status_t     res_status;
  logic [11:0] res_offset;
  logic [9:0]  res_bytes;

  // handshake: request stage moves when the result register is free
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_func   <= func;
      req_size   <= request_size;
      req_offset <= free_offset;
    end
  end

  // class and slot decode
  scba_decode u_decode (
    .func         (req_func),
    .request_size (req_size),
    .free_offset  (req_offset),
    .op           (op)
  );

  // bitmap store and slot search
  scba_bitmaps u_bitmaps (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .op          (op),
    .status      (res_status),
    .slot_offset (res_offset),
    .slot_bytes  (res_bytes)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status      <= res_status;
      slot_offset <= res_offset;
      slot_bytes  <= res_bytes;
    end
  end

`ifndef SYNTHESIS
  // a granted or freed slot has a power-of-two size
  a_slot_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_GRANTED || status == ST_FREED) |-> $onehot(slot_bytes))
    else $error("slot size not a power of two");

  // a granted or freed slot starts on its own size boundary
  a_slot_align: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_GRANTED || status == ST_FREED)
      |-> ((slot_offset & {2'b00, slot_bytes - 10'd1}) == 12'd0))
    else $error("slot offset misaligned");

  // failures carry no slot
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_CLASS || status == ST_FULL || status == ST_BAD)
      |-> (slot_offset == 12'd0) && (slot_bytes == 10'd0))
    else $error("failed request reports a slot");

  // back-pressure only comes from a held request
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> req_valid && out_valid && !out_ready)
    else $error("request stalled without cause");
`endif

endmodule
